// ===== hdl/gbrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbrw_pkg
// Shared types and constants for the grid block ray walk.
// ----------------------------------------------------------------------------
package gbrw_pkg;
    localparam int BLOCK_SHIFT_DEF = 23;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_STEPS_DEF   = 64;

    localparam logic [31:0] FRAC_ONE    = 32'h0001_0000;
    localparam logic [31:0] SLOPE_FLAT  = 32'h0100_0000;  // 256.0
    localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIVY,
        ST_DIVX,
        ST_MULY,
        ST_MULX,
        ST_ICPT,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic setup;
        logic div_start;
        logic div_sel_x;
        logic mul_y;
        logic mul_x;
        logic icpt;
        logic step;
    } ctrl_t;

    typedef struct packed {
        logic div_done;
        logic done_blk;
        logic cap;
    } stat_t;
endpackage

// ===== hdl/gbrw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbrw_div
// Iterative restoring divider: saturating signed 16.16 divide by a magnitude.
// ----------------------------------------------------------------------------
module gbrw_div
    import gbrw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [31:0] quot
);
    logic [47:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic [47:0] dividend_reg, dividend_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        sat_reg, sat_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] ua;
    logic [48:0] trial;

    assign ua    = num[31] ? (~num + 32'd1) : num;
    assign trial = {rem_reg, dividend_reg[47]} - {16'd0, den_reg};

    always_comb
    begin
        rem_next      = rem_reg;
        q_next        = q_reg;
        dividend_next = dividend_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        sat_next      = sat_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start)
        begin
            rem_next      = '0;
            q_next        = '0;
            dividend_next = {ua, 16'd0};
            den_next      = den;
            neg_next      = num[31];
            // Saturate when the quotient would not fit.
            sat_next      = ({15'd0, ua[31:14]} >= den);
            cnt_next      = 6'd48;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[48])
            begin
                rem_next = {rem_reg[46:0], dividend_reg[47]};
                q_next   = {q_reg[46:0], 1'b0};
            end
            else
            begin
                rem_next = trial[47:0];
                q_next   = {q_reg[46:0], 1'b1};
            end
            dividend_next = {dividend_reg[46:0], 1'b0};
            cnt_next      = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        dividend_reg <= dividend_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        sat_reg      <= sat_next;
    end

    assign done = done_reg;
    always_comb
    begin
        if (sat_reg)
            quot = neg_reg ? SAT_NEG : SAT_POS;
        else
            quot = neg_reg ? (~q_reg[31:0] + 32'd1) : q_reg[31:0];
    end
endmodule

// ===== hdl/gbrw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbrw_datapath
// Offsets, block indices, slopes, intercepts and the block stepping registers.
// ----------------------------------------------------------------------------
module gbrw_datapath
    import gbrw_pkg::*;
#(
    parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  logic [127:0] in_data,
    output logic [8:0]  block_col,
    output logic [8:0]  block_row
);
    localparam int B2F = BLOCK_SHIFT - FRAC_BITS;
    localparam int BW  = 32 - BLOCK_SHIFT;
    localparam int CW  = $clog2(MAX_STEPS + 1);

    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic signed [BW-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic signed [BW-1:0] mx_reg, my_reg;
    logic [1:0]  sx_reg, sy_reg;
    logic [16:0] px_reg, py_reg;
    logic signed [31:0] xslope_reg, yslope_reg, xicpt_reg, yicpt_reg;
    logic signed [31:0] prodx_reg, prody_reg;
    logic        div_to_x_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] x1n, y1n, x1o, y1o;
    logic signed [31:0] fx, fy;
    logic [31:0] div_num;
    logic [32:0] div_den, magx, magy;
    logic [31:0] div_q;
    logic        div_done;
    logic signed [49:0] mul_full;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [BW-1:0] step_x, step_y;

    assign x1o = $signed(in_data[31:0]) - $signed(origin_x);
    assign y1o = $signed(in_data[63:32]) - $signed(origin_y);
    assign x1n = (x1o[BLOCK_SHIFT-1:0] == '0) ? x1o + $signed(FRAC_ONE) : x1o;
    assign y1n = (y1o[BLOCK_SHIFT-1:0] == '0) ? y1o + $signed(FRAC_ONE) : y1o;
    assign fx  = x1_reg >>> B2F;
    assign fy  = y1_reg >>> B2F;
    assign magx = dx_reg[31] ? (33'd0 - {1'b1, dx_reg}) : {1'b0, dx_reg};
    assign magy = dy_reg[31] ? (33'd0 - {1'b1, dy_reg}) : {1'b0, dy_reg};
    assign div_num = ctrl.div_sel_x ? dx_reg : dy_reg;
    assign div_den = ctrl.div_sel_x ? magy : magx;

    gbrw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // The partial distance reaches 1.0, so it enters the product zero-extended.
    assign mul_a    = ctrl.mul_y ? $signed({1'b0, px_reg}) : $signed({1'b0, py_reg});
    assign mul_b    = ctrl.mul_y ? yslope_reg : xslope_reg;
    assign mul_full = mul_a * mul_b;
    assign step_x = (sx_reg == 2'b01) ? BW'(1) : ((sx_reg == 2'b11) ? '1 : '0);
    assign step_y = (sy_reg == 2'b01) ? BW'(1) : ((sy_reg == 2'b11) ? '1 : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x1_reg <= x1n;
            y1_reg <= y1n;
            x2_reg <= $signed(in_data[95:64]) - $signed(origin_x);
            y2_reg <= $signed(in_data[127:96]) - $signed(origin_y);
        end
        if (ctrl.prep)
        begin
            dx_reg  <= x2_reg - x1_reg;
            dy_reg  <= y2_reg - y1_reg;
            bx1_reg <= BW'(x1_reg >>> BLOCK_SHIFT);
            by1_reg <= BW'(y1_reg >>> BLOCK_SHIFT);
            bx2_reg <= BW'(x2_reg >>> BLOCK_SHIFT);
            by2_reg <= BW'(y2_reg >>> BLOCK_SHIFT);
        end
        if (ctrl.setup)
        begin
            mx_reg <= bx1_reg;
            my_reg <= by1_reg;
            if (bx2_reg > bx1_reg)
            begin
                sx_reg <= 2'b01;
                px_reg <= 17'h10000 - {1'b0, fx[15:0]};
            end
            else if (bx2_reg < bx1_reg)
            begin
                sx_reg <= 2'b11;
                px_reg <= {1'b0, fx[15:0]};
            end
            else
            begin
                sx_reg <= 2'b00;
                px_reg <= 17'h10000;
                yslope_reg <= SLOPE_FLAT;
            end
            if (by2_reg > by1_reg)
            begin
                sy_reg <= 2'b01;
                py_reg <= 17'h10000 - {1'b0, fy[15:0]};
            end
            else if (by2_reg < by1_reg)
            begin
                sy_reg <= 2'b11;
                py_reg <= {1'b0, fy[15:0]};
            end
            else
            begin
                sy_reg <= 2'b00;
                py_reg <= 17'h10000;
                xslope_reg <= SLOPE_FLAT;
            end
        end
        // The second divide starts in the cycle the first one finishes, so the
        // destination is remembered from the start of each divide.
        if (ctrl.div_start)
            div_to_x_reg <= ctrl.div_sel_x;
        if (div_done)
        begin
            if (div_to_x_reg)
            begin
                if (sy_reg != 2'b00)
                    xslope_reg <= div_q;
            end
            else if (sx_reg != 2'b00)
                yslope_reg <= div_q;
        end
        if (ctrl.mul_y)
            prody_reg <= 32'(mul_full >>> 16);
        if (ctrl.mul_x)
            prodx_reg <= 32'(mul_full >>> 16);
        if (ctrl.icpt)
        begin
            yicpt_reg <= fy + prody_reg;
            xicpt_reg <= fx + prodx_reg;
        end
        if (ctrl.step)
        begin
            if ($signed(yicpt_reg >>> 16) == 32'(my_reg))
            begin
                yicpt_reg <= yicpt_reg + yslope_reg;
                mx_reg    <= mx_reg + step_x;
            end
            else if ($signed(xicpt_reg >>> 16) == 32'(mx_reg))
            begin
                xicpt_reg <= xicpt_reg + xslope_reg;
                my_reg    <= my_reg + step_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctrl.icpt)
            cnt_reg <= CW'(1);
        else if (ctrl.step)
            cnt_reg <= cnt_reg + CW'(1);
    end

    assign stat.div_done = div_done;
    assign stat.done_blk = (mx_reg == bx2_reg) && (my_reg == by2_reg);
    assign stat.cap      = (cnt_reg == CW'(MAX_STEPS));
    assign block_col = 9'(mx_reg);
    assign block_row = 9'(my_reg);
endmodule

// ===== hdl/gbrw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbrw_ctrl
// Sequencer: load, prep, setup, two divides, two multiplies, intercepts, then the block walk.
// ----------------------------------------------------------------------------
module gbrw_ctrl
    import gbrw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  in_ready,
    output logic  out_valid,
    output logic  out_last
);
    state_t state_reg, state_next;
    logic   out_fire;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = stat.done_blk || stat.cap;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_fire;
                if (in_fire)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                ctrl.prep  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                ctrl.setup     = 1'b1;
                ctrl.div_start = 1'b1;
                state_next     = ST_DIVY;
            end
            ST_DIVY:
            begin
                if (stat.div_done)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel_x = 1'b1;
                    state_next     = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                ctrl.div_sel_x = 1'b1;
                if (stat.div_done)
                    state_next = ST_MULY;
            end
            ST_MULY:
            begin
                ctrl.mul_y = 1'b1;
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                ctrl.mul_x = 1'b1;
                state_next = ST_ICPT;
            end
            ST_ICPT:
            begin
                ctrl.icpt  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    if (out_last)
                        state_next = ST_IDLE;
                    else
                        ctrl.step = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("input taken during walk");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last) |=> state_reg == ST_IDLE) else $error("walk did not end");
    a_step_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> state_reg == ST_WALK) else $error("step outside walk");
endmodule

// ===== hdl/grid_block_ray_walk_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_block_ray_walk_top
// Walks a segment across a block grid and streams out each visited block.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   start_x, start_y, end_x, end_y (128 bits)
// m_axis    out  block_col, block_row; tlast marks the final block
// apb       cfg  origin_x at 0x0, origin_y at 0x4
//
// One segment goes through prep and setup, two serial divides (48 steps each),
// two multiplies and the intercept step, then the walk emits one block per
// cycle while the output does not stall (up to MAX_STEPS blocks). The next
// segment is taken only after the last block. The serial divider sets the
// setup time. Reset clears the sequencer and origins; output stalls hold the
// walk.
// ----------------------------------------------------------------------------
module grid_block_ray_walk_top
    import gbrw_pkg::*;
#(
    parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // block_col, block_row, zero fill
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [31:0] origin_x_reg, origin_y_reg;
    ctrl_t ctrl;
    stat_t stat;
    logic [8:0] block_col, block_row;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == REG_ORIGIN_X)
                origin_x_reg <= pwdata;
            else if (paddr == REG_ORIGIN_Y)
                origin_y_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (paddr == REG_ORIGIN_X)
            prdata = origin_x_reg;
        else if (paddr == REG_ORIGIN_Y)
            prdata = origin_y_reg;
        else
            prdata = '0;
    end

    gbrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast)
    );

    gbrw_datapath #(
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .in_data   (s_axis_tdata),
        .block_col (block_col),
        .block_row (block_row)
    );

    assign m_axis_tdata = {6'd0, block_row, block_col};
endmodule

// ===== dv/tb_grid_block_ray_walk_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_block_ray_walk_top
// Self-checking bench for the grid block ray walk. Segments are sent on the
// input stream, a local model predicts the visited blocks, and each output
// transaction is compared against the oldest predicted block.
// ----------------------------------------------------------------------------
module tb_grid_block_ray_walk_top;
    import gbrw_pkg::*;

    localparam int BSH      = BLOCK_SHIFT_DEF;
    localparam int STEP_CAP = MAX_STEPS_DEF;
    localparam int B2F      = BSH - FRAC_BITS;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
        logic       last;
    } block_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    block_t      expected_blocks[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    int          burst_left;

    grid_block_ray_walk_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stall pattern: a long open stretch, then light stalls, then heavy stalls, repeating.
    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 400;
            if (phase < 120)
                m_axis_tready <= 1'b1;
            else if (phase < 260)
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    function automatic logic signed [31:0] slope_div(logic signed [31:0] a,
                                                      logic [32:0] m);
        logic [32:0] ua;
        logic [63:0] q;
        ua = a[31] ? 33'(-$signed({a[31], a})) : {1'b0, a};
        if ((ua >> 14) >= m)
            return a[31] ? SAT_NEG : SAT_POS;
        q = ({31'd0, ua} << 16) / {31'd0, m};
        return a[31] ? -q[31:0] : q[31:0];
    endfunction

    function automatic logic [32:0] magnitude(logic signed [31:0] v);
        return v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
    endfunction

    function automatic logic signed [31:0] fix_mul(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >>> 16);
    endfunction

    task automatic predict_walk(logic signed [31:0] x1, logic signed [31:0] y1,
                                logic signed [31:0] x2, logic signed [31:0] y2);
        logic signed [31:0] bx1, by1, bx2, by2, dx, dy;
        logic signed [31:0] partial, xsl, ysl, xic, yic, mx, my, sx, sy;
        block_t b;
        int n;
        bit done;
        if (((x1 - org_x) & ((32'd1 << BSH) - 1)) == 0)
            x1 = x1 + FRAC_ONE;
        if (((y1 - org_y) & ((32'd1 << BSH) - 1)) == 0)
            y1 = y1 + FRAC_ONE;
        x1 = x1 - org_x;
        y1 = y1 - org_y;
        x2 = x2 - org_x;
        y2 = y2 - org_y;
        bx1 = x1 >>> BSH;
        by1 = y1 >>> BSH;
        bx2 = x2 >>> BSH;
        by2 = y2 >>> BSH;
        dx = x2 - x1;
        dy = y2 - y1;
        if (bx2 != bx1)
        begin
            sx = (bx2 > bx1) ? 1 : -1;
            partial = (x1 >>> B2F) & 32'hFFFF;
            if (bx2 > bx1)
                partial = FRAC_ONE - partial;
            ysl = slope_div(dy, magnitude(dx));
        end
        else
        begin
            sx = 0;
            partial = FRAC_ONE;
            ysl = SLOPE_FLAT;
        end
        yic = (y1 >>> B2F) + fix_mul(partial, ysl);
        if (by2 != by1)
        begin
            sy = (by2 > by1) ? 1 : -1;
            partial = (y1 >>> B2F) & 32'hFFFF;
            if (by2 > by1)
                partial = FRAC_ONE - partial;
            xsl = slope_div(dx, magnitude(dy));
        end
        else
        begin
            sy = 0;
            partial = FRAC_ONE;
            xsl = SLOPE_FLAT;
        end
        xic = (x1 >>> B2F) + fix_mul(partial, xsl);
        mx = bx1;
        my = by1;
        n = 0;
        while (n < STEP_CAP)
        begin
            done = (mx == bx2) && (my == by2);
            n++;
            b.col = mx[8:0];
            b.row = my[8:0];
            b.last = done || (n == STEP_CAP);
            expected_blocks.push_back(b);
            if (done)
                break;
            if ((yic >>> 16) == my)
            begin
                yic = yic + ysl;
                mx = mx + sx;
            end
            else if ((xic >>> 16) == mx)
            begin
                xic = xic + xsl;
                my = my + sy;
            end
        end
    endtask

    // Checks every output transaction against the oldest predicted block.
    always @(posedge clk)
    begin
        block_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected block col=%0d row=%0d last=%0b",
                             m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tlast);
            end
            else
            begin
                e = expected_blocks.pop_front();
                if (m_axis_tdata[8:0] !== e.col || m_axis_tdata[17:9] !== e.row ||
                    m_axis_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("block mismatch: exp col=%h row=%h last=%b, got col=%h row=%h last=%b",
                                 e.col, e.row, e.last, m_axis_tdata[8:0],
                                 m_axis_tdata[17:9], m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG);
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_origin(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_ORIGIN_X)
            org_x = value;
        else
            org_y = value;
    endtask

    // Sends one segment; gaps between bursts are inserted here. Within a
    // burst tvalid stays high from one transaction to the next.
    task automatic send_segment(logic [31:0] x1, logic [31:0] y1,
                                logic [31:0] x2, logic [31:0] y2);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y2, x2, y1, x1};
        predict_walk(x1, y1, x2, y2);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int spread);
        return base + $urandom_range(0, 2 * spread) - spread;
    endfunction

    task automatic test_directed();
        send_segment(32'h0010_0000, 32'h0010_0000, 32'h0400_0000, 32'h0200_0000);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0);                 // start on block edges
        send_segment(32'h0080_0000, 32'h0100_0000, 32'h0500_0000, 32'h0100_0000);
        send_segment(32'h0180_0000, 32'h0000_1234, 32'h0180_0000, 32'hFA00_0000);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_segment(32'h8000_0000, 32'h0000_0100, 32'h7FFF_0000, 32'h0000_0200);
        send_segment(32'h0000_0100, 32'h8000_0000, 32'h0000_0200, 32'h7FFF_0000);
        send_segment(32'hFF00_0000, 32'h0000_0001, 32'h0100_0000, 32'h0000_0002);
        send_segment(32'h0300_0000, 32'h0700_0000, 32'hFD00_0000, 32'hF900_0000);
        send_segment(32'h0012_3456, 32'h0076_5432, 32'h0012_3457, 32'h7F00_0000);
        send_segment(32'h0, 32'h0, 32'h8000_0000, 32'h0);
        send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [31:0] x1, y1, x2, y2;
        repeat (count)
        begin
            x1 = org_x + ($urandom() >> $urandom_range(0, 8));
            y1 = org_y + ($urandom() >> $urandom_range(0, 8));
            if ($urandom_range(0, 4) == 0)
            begin
                x1 = $urandom();
                y1 = $urandom();
            end
            else if ($urandom_range(0, 3) == 0)
                x1 = {x1[31:BSH], {BSH{1'b0}}} + org_x;
            if ($urandom_range(0, 4) == 0)
            begin
                x2 = $urandom();
                y2 = $urandom();
            end
            else
            begin
                x2 = near(x1, 32'h0600_0000 >> $urandom_range(0, 4));
                y2 = near(y1, 32'h0600_0000 >> $urandom_range(0, 4));
            end
            send_segment(x1, y1, x2, y2);
        end
        drain_results();
    endtask

    task automatic test_origins();
        write_origin(REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_origin(REG_ORIGIN_Y, 32'h8000_0000);
        test_random(25);
        write_origin(REG_ORIGIN_X, 32'h0034_5678);
        write_origin(REG_ORIGIN_Y, 32'hFF80_0000);
        test_random(25);
        write_origin(REG_ORIGIN_X, 32'h8000_0000);
        write_origin(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        test_random(15);
        write_origin(REG_ORIGIN_X, $urandom());
        write_origin(REG_ORIGIN_Y, $urandom());
        test_random(15);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        org_x         = '0;
        org_y         = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        burst_left    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(30);
        test_origins();
        if (mismatches == 0 && expected_blocks.size() == 0 && !timed_out)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
